[hw/rtl/bptc_pkg.sv]
package bptc_pkg;

    localparam int NUM_MASKS  = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int LINES_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int LEVEL_W    = 12;
    localparam int MAX_PAIRS  = 16;

    localparam logic [BYTE_W-1:0]  CMD_SEND      = 8'd115;
    localparam logic [12:0]        FULL_ON_COUNT = 13'h1000;

    typedef logic [CFG_DATA_W-1:0] t_mask;
    typedef logic [LEVEL_W-1:0]    t_level;

    localparam t_mask MASK_RESET [NUM_MASKS] = '{
        16'd224, 16'd16, 16'd32768, 16'd8192, 16'd20480, 16'd771, 16'd771, 16'd3072
    };

endpackage

[hw/rtl/bptc_in_if.sv]
interface bptc_in_if
    import bptc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [LINES_W-1:0]       buttons;
    logic signed [BYTE_W-1:0] cmd_byte;

    modport source (output valid, kind, buttons, cmd_byte, input ready);
    modport sink   (input valid, kind, buttons, cmd_byte, output ready);
endinterface

[hw/rtl/bptc_out_if.sv]
interface bptc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel;
    logic [12:0] on_count;
    logic [11:0] off_count;
    logic        last;

    modport source (output valid, channel, on_count, off_count, last, input ready);
    modport sink   (input valid, channel, on_count, off_count, last, output ready);
endinterface

[hw/rtl/button_toggle_pwm_phase_controller.sv]
// Per item: a command byte is taken in idle; 's' sends NPAIR on/off words; a button sample
// steps each button, walks NPAIR channels per button that fires, then sends NPAIR words if
// any channel toggled. NPAIR = min(NUM_CHANNELS, 16). Words go out one per cycle while the
// sink is ready, from an output register loaded by the step that made them.
// Throughput: one item at a time; steps one button or channel per cycle, stalling in emit.
// Reset (synchronous, active low) clears levels, press counts, selected channel; reloads masks.
module button_toggle_pwm_phase_controller
    import bptc_pkg::*;
#(
    parameter int NUM_BUTTONS     = 8,
    parameter int NUM_CHANNELS    = 16,
    parameter int PRESS_THRESHOLD = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bptc_in_if.sink               i_in,
    bptc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Derived sizes
    localparam int NPAIR = (NUM_CHANNELS < MAX_PAIRS) ? NUM_CHANNELS : MAX_PAIRS;
    localparam int CHW   = $clog2(NPAIR);
    localparam int LW    = $clog2(NUM_CHANNELS);
    localparam int BW    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int PCW   = $clog2(PRESS_THRESHOLD + 2);
    localparam int HALF  = NUM_CHANNELS / 2;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BTN  = 2'd1;   // one button per cycle
    localparam logic [1:0] S_TOG  = 2'd2;   // one channel per cycle, toggling
    localparam logic [1:0] S_EMIT = 2'd3;   // one on/off word per cycle while the output is free

    logic [1:0]           r_state;
    t_mask                r_masks [NUM_MASKS];
    logic                 r_full  [NUM_CHANNELS];   // level is full on (0xFFFF)
    t_level               r_lvl   [NUM_CHANNELS];
    logic [PCW-1:0]       r_press [NUM_BUTTONS];
    logic [3:0]           r_sel;
    logic [LINES_W-1:0]   r_lines;
    logic [BW-1:0]        r_btn;
    logic [CHW-1:0]       r_ch;
    t_mask                r_mask;
    logic                 r_seen;
    logic                 r_turn_on;
    logic                 r_send;
    logic [LEVEL_W-1:0]   r_sum;
    logic                 r_out_valid;
    logic [3:0]           r_out_ch;
    logic [12:0]          r_out_on;
    logic [11:0]          r_out_off;
    logic                 r_out_last;

    // Input decode
    logic                 accept;
    logic [BYTE_W-1:0]    raw;
    logic [3:0]           step;
    logic [15:0]          scaled;
    t_level               set_level;
    logic                 sel_ok;

    // Button step
    logic                 pressed;
    logic                 btn_in_map;
    logic [PCW-1:0]       n_cnt;
    logic                 fire;
    logic                 btn_last;

    // Channel step
    logic [LW-1:0]        ch_idx;
    logic                 ch_last;
    logic                 mask_bit;
    logic                 ch_zero;
    logic                 cur_on;
    logic                 out_free;
    logic [LEVEL_W-1:0]   base_sum;
    logic [LEVEL_W-1:0]   n_sum;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Level set: 0x0FFF*k/16 = ((k << 12) - k) >> 4
    assign raw       = i_in.cmd_byte;
    assign step      = raw[3:0];
    assign scaled    = {step, 12'd0} - 16'(step);
    assign set_level = scaled[15:4];
    assign sel_ok    = (int'(r_sel) < NUM_CHANNELS);

    // Buttons past the eighth have no line and no mask: always released
    assign btn_in_map = (int'(r_btn) < NUM_MASKS);
    assign pressed    = btn_in_map && !r_lines[3'(r_btn)];
    assign btn_last   = (r_btn == BW'(NUM_BUTTONS - 1));

    always_comb begin
        if (!pressed) begin
            n_cnt = '0;
        end else if (r_press[r_btn] <= PCW'(PRESS_THRESHOLD)) begin
            n_cnt = r_press[r_btn] + PCW'(1);
        end else begin
            n_cnt = r_press[r_btn];
        end
    end

    assign fire = pressed && (n_cnt == PCW'(PRESS_THRESHOLD));

    assign ch_idx   = LW'(r_ch);
    assign ch_last  = (r_ch == CHW'(NPAIR - 1));
    assign mask_bit = r_mask[4'(r_ch)];
    assign ch_zero  = !r_full[ch_idx] && (r_lvl[ch_idx] == '0);
    // first masked channel decides on or off for the whole mask
    assign cur_on   = r_seen ? r_turn_on : ch_zero;

    // phase sum restarts at the middle channel
    assign base_sum = (int'(r_ch) == HALF) ? '0 : r_sum;
    assign n_sum    = base_sum + r_lvl[ch_idx];
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= '0;
            r_btn       <= '0;
            r_ch        <= '0;
            r_seen      <= 1'b0;
            r_turn_on   <= 1'b0;
            r_send      <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_MASKS; i++) begin
                r_masks[i] <= MASK_RESET[i];
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_full[i] <= 1'b0;
                r_lvl[i]  <= '0;
            end
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_press[i] <= '0;
            end
        end else begin
            if (i_cfg_we && (int'(i_cfg_idx) < NUM_MASKS)) begin
                r_masks[3'(i_cfg_idx)] <= i_cfg_data;
            end

            if (o_out.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!i_in.kind) begin
                            r_lines <= i_in.buttons;
                            r_btn   <= '0;
                            r_send  <= 1'b0;
                            r_state <= S_BTN;
                        end else if (!raw[7]) begin
                            if (raw == CMD_SEND) begin
                                r_ch    <= '0;
                                r_sum   <= '0;
                                r_state <= S_EMIT;
                            end else if (raw < 8'd16) begin
                                r_sel <= raw[3:0];
                            end else if (raw < 8'd32) begin
                                if (sel_ok) begin
                                    r_full[LW'(r_sel)] <= 1'b0;
                                    r_lvl[LW'(r_sel)]  <= set_level;
                                end
                            end
                        end
                    end
                end
                S_BTN: begin
                    r_press[r_btn] <= n_cnt;
                    if (fire) begin
                        r_mask  <= r_masks[3'(r_btn)];
                        r_ch    <= '0;
                        r_seen  <= 1'b0;
                        r_state <= S_TOG;
                    end else if (btn_last) begin
                        r_ch    <= '0;
                        r_sum   <= '0;
                        r_state <= r_send ? S_EMIT : S_IDLE;
                    end else begin
                        r_btn <= r_btn + BW'(1);
                    end
                end
                S_TOG: begin
                    if (mask_bit) begin
                        r_seen            <= 1'b1;
                        r_turn_on         <= cur_on;
                        r_full[ch_idx]    <= cur_on;
                        r_lvl[ch_idx]     <= '0;
                    end
                    if (ch_last) begin
                        if (btn_last) begin
                            r_ch    <= '0;
                            r_sum   <= '0;
                            r_state <= (r_send || r_seen || mask_bit) ? S_EMIT : S_IDLE;
                        end else begin
                            r_send  <= r_send || r_seen || mask_bit;
                            r_btn   <= r_btn + BW'(1);
                            r_state <= S_BTN;
                        end
                    end else begin
                        r_ch <= r_ch + CHW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_sum       <= r_full[ch_idx] ? base_sum : n_sum;
                        if (ch_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch <= r_ch + CHW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_ch   <= 4'(r_ch);
            r_out_last <= ch_last;
            if (r_full[ch_idx]) begin
                r_out_on  <= FULL_ON_COUNT;
                r_out_off <= '0;
            end else begin
                r_out_on  <= 13'(base_sum);
                r_out_off <= n_sum;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.channel   = r_out_ch;
    assign o_out.on_count  = r_out_on;
    assign o_out.off_count = r_out_off;
    assign o_out.last      = r_out_last;

endmodule

[dv/bptc_pair_checker.sv]
module bptc_pair_checker
    import bptc_pkg::*;
#(
    parameter int                NUM_BUTTONS     = 8,
    parameter int                NUM_CHANNELS    = 16,
    parameter int                PRESS_THRESHOLD = 3,
    parameter bit                KIND_CMD        = 1'b1,
    parameter logic [BYTE_W-1:0] CMD_LEVEL_BASE  = 8'd16,
    parameter logic [BYTE_W-1:0] CMD_LEVEL_END   = 8'd32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bptc_in_if                    i_in,
    bptc_out_if                   i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pairs_due,
    output int                    o_pairs_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NPAIR       = (NUM_CHANNELS < MAX_PAIRS) ? NUM_CHANNELS : MAX_PAIRS;
    localparam logic [15:0] LEVEL_FULL  = 16'hFFFF;
    localparam int          PHASE_MAX   = 'h0FFF;
    localparam int          LEVEL_STEPS = 16;

    typedef struct packed {
        logic [3:0]  channel;
        logic [12:0] on_count;
        logic [11:0] off_count;
        logic        last;
    } pair_word_t;

    t_mask       btn_mask    [NUM_MASKS];
    logic [15:0] light_level [NUM_CHANNELS];
    int          press_cnt   [NUM_BUTTONS];
    logic [3:0]  sel_chan;
    pair_word_t  pairs_due [$];
    int          fail_cnt;
    int          checked_cnt;

    task automatic reset_lights();
        foreach (btn_mask[i]) btn_mask[i] = MASK_RESET[i];
        foreach (light_level[c]) light_level[c] = '0;
        foreach (press_cnt[b]) press_cnt[b] = 0;
        sel_chan = '0;
        pairs_due.delete();
    endtask

    // One word per channel, phase sum restarts halfway through.
    task automatic queue_pairs();
        logic [11:0] phase;
        pair_word_t  p;
        phase = '0;
        for (int c = 0; c < NPAIR; c++) begin
            if (c == NUM_CHANNELS / 2) phase = '0;
            p.channel = c[3:0];
            if (light_level[c] == LEVEL_FULL) begin
                p.on_count  = FULL_ON_COUNT;
                p.off_count = '0;
            end else begin
                p.on_count  = {1'b0, phase};
                phase       = phase + light_level[c][11:0];
                p.off_count = phase;
            end
            p.last = (c == NPAIR - 1);
            pairs_due.push_back(p);
        end
    endtask

    // First masked channel decides on or off for all of them.
    function automatic bit toggle_masked(t_mask m);
        bit seen;
        bit turn_on;
        seen    = 1'b0;
        turn_on = 1'b0;
        for (int c = 0; c < NPAIR; c++) begin
            if (m[c]) begin
                if (!seen) begin
                    seen    = 1'b1;
                    turn_on = (light_level[c] == '0);
                end
                light_level[c] = turn_on ? LEVEL_FULL : '0;
            end
        end
        return seen;
    endfunction

    task automatic run_sample(logic [LINES_W-1:0] lines);
        bit fire;
        bit pressed;
        fire = 1'b0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            pressed = (b < LINES_W) && !lines[b];
            if (!pressed) begin
                press_cnt[b] = 0;
            end else begin
                if (press_cnt[b] <= PRESS_THRESHOLD) press_cnt[b]++;
                if (press_cnt[b] == PRESS_THRESHOLD && b < NUM_MASKS) begin
                    if (toggle_masked(btn_mask[b])) fire = 1'b1;
                end
            end
        end
        if (fire) queue_pairs();
    endtask

    task automatic run_command(logic [BYTE_W-1:0] raw);
        int lvl;
        if (raw[BYTE_W-1]) begin
            // negative byte: dropped
        end else if (raw == CMD_SEND) begin
            queue_pairs();
        end else if (raw < CMD_LEVEL_BASE) begin
            sel_chan = raw[3:0];
        end else if (raw < CMD_LEVEL_END) begin
            if (sel_chan < NUM_CHANNELS) begin
                lvl = (PHASE_MAX * (int'(raw) - int'(CMD_LEVEL_BASE))) / LEVEL_STEPS;
                light_level[sel_chan] = 16'(lvl);
            end
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        pair_word_t want;
        if (!i_rst_n) begin
            reset_lights();
        end else begin
            // drain before predict: a word leaving now belongs to an older input
            if (i_out.valid && i_out.ready) begin
                if (pairs_due.size() == 0) begin
                    $error("unexpected pair word: channel %0d on %0d off %0d last %0d",
                           i_out.channel, i_out.on_count, i_out.off_count, i_out.last);
                    fail_cnt++;
                end else begin
                    want = pairs_due.pop_front();
                    check_field("channel", 16'(want.channel), 16'(i_out.channel));
                    check_field("on_count", 16'(want.on_count), 16'(i_out.on_count));
                    check_field("off_count", 16'(want.off_count), 16'(i_out.off_count));
                    check_field("last", 16'(want.last), 16'(i_out.last));
                    checked_cnt++;
                end
            end
            if (i_cfg_we && i_cfg_idx < NUM_MASKS) btn_mask[3'(i_cfg_idx)] = i_cfg_data;
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind == KIND_CMD) run_command(i_in.cmd_byte);
                else run_sample(i_in.buttons);
            end
        end
        o_fail_count    <= fail_cnt;
        o_pairs_due     <= pairs_due.size();
        o_pairs_checked <= checked_cnt;
    end

endmodule

[dv/tb_top.sv]
// Top of the light controller bench: clock, one reset, stimulus and verdict.
// All prediction and comparison lives in bptc_pair_checker; this module
// only drives the input channel, the mask port and the output ready.
module tb_top;
    import bptc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // block configuration, shared with the checker
    localparam int NUM_BUTTONS     = 8;
    localparam int NUM_CHANNELS    = 16;
    localparam int PRESS_THRESHOLD = 3;

    // input word kinds and command byte ranges
    localparam bit                KIND_SAMPLE    = 1'b0;
    localparam bit                KIND_CMD       = 1'b1;
    localparam logic [BYTE_W-1:0] CMD_LEVEL_BASE = 8'd16;  // selects sit below this
    localparam logic [BYTE_W-1:0] CMD_LEVEL_END  = 8'd32;  // level sets sit below this
    localparam logic [LINES_W-1:0] ALL_RELEASED  = '1;

    // a button word with every button firing walks every channel once per button and may
    // produce nothing, so idle phases wait out that whole walk
    localparam int DRAIN_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int NUM_PHASES       = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bptc_in_if  in_bus ();
    bptc_out_if out_bus ();

    int fail_count;
    int pairs_due;
    int pairs_checked;

    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int directed_sent;
    int idle_cycles;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    button_toggle_pwm_phase_controller #(
        .NUM_BUTTONS    (NUM_BUTTONS),
        .NUM_CHANNELS   (NUM_CHANNELS),
        .PRESS_THRESHOLD(PRESS_THRESHOLD)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_bus),
        .o_out     (out_bus),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    bptc_pair_checker #(
        .NUM_BUTTONS    (NUM_BUTTONS),
        .NUM_CHANNELS   (NUM_CHANNELS),
        .PRESS_THRESHOLD(PRESS_THRESHOLD),
        .KIND_CMD       (KIND_CMD),
        .CMD_LEVEL_BASE (CMD_LEVEL_BASE),
        .CMD_LEVEL_END  (CMD_LEVEL_END)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_bus),
        .i_out          (out_bus),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pairs_due    (pairs_due),
        .o_pairs_checked(pairs_checked)
    );

    // Output ready: redrawn every cycle so stalls land on any pair of the burst.
    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any handshake on either channel rearms it.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d pairs still due",
                     idle_cycles, pairs_due);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Present one word and hold it until taken. Valid stays high on return,
    // so back-to-back words never lower and raise it in the same step.
    task automatic send_word(input logic kind, input logic [LINES_W-1:0] lines,
                             input logic signed [BYTE_W-1:0] cmd);
        logic [BYTE_W-1:0] raw;
        raw = cmd;
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.kind     <= kind;
        in_bus.buttons  <= lines;
        in_bus.cmd_byte <= cmd;
        @(posedge i_clk);
        while (in_bus.ready !== 1'b1) @(posedge i_clk);
        // bytes the block just drops do not count toward the item budget
        if (kind == KIND_SAMPLE || (!raw[BYTE_W-1] && (raw < CMD_LEVEL_END || raw == CMD_SEND)))
            words_sent++;
    endtask

    // Block idle: nothing due, and long enough for a silent button word to finish.
    task automatic settle();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pairs_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_masks(input t_mask m [NUM_MASKS]);
        for (int i = 0; i < NUM_MASKS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= m[i];
            @(posedge i_clk);
        end
        // index past the mask bank: must be dropped
        i_cfg_idx  <= CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, NUM_MASKS));
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Directed opener, reset masks in place.
    task automatic directed_words();
        send_word(KIND_CMD, 8'($urandom), CMD_SEND);          // all channels dark
        send_word(KIND_CMD, 8'($urandom), 8'sd0);             // select first channel
        send_word(KIND_CMD, 8'($urandom), 8'sd31);            // top level
        send_word(KIND_CMD, 8'($urandom), 8'sd15);            // select last channel
        send_word(KIND_CMD, 8'($urandom), 8'sd17);            // lowest nonzero level
        send_word(KIND_CMD, 8'($urandom), 8'sd7);
        send_word(KIND_CMD, 8'($urandom), 8'sd24);
        send_word(KIND_CMD, 8'($urandom), -8'sd128);          // negative bytes dropped
        send_word(KIND_CMD, 8'($urandom), -8'sd1);
        send_word(KIND_CMD, 8'($urandom), 8'sd32);            // just past level range
        send_word(KIND_CMD, 8'($urandom), 8'sd127);
        send_word(KIND_CMD, 8'h00, CMD_SEND);                 // lines ignored on commands
        send_word(KIND_SAMPLE, ALL_RELEASED, CMD_SEND);       // byte ignored on samples
        // button 0 held: toggles on the third sample, then saturates
        repeat (5) send_word(KIND_SAMPLE, 8'hFE, 8'($urandom));
        // everything held: all other buttons fire on the same sample
        repeat (3) send_word(KIND_SAMPLE, 8'h00, 8'($urandom));
        send_word(KIND_SAMPLE, ALL_RELEASED, 8'($urandom));
        send_word(KIND_CMD, 8'($urandom), 8'sd0);
        send_word(KIND_CMD, 8'($urandom), 8'(CMD_LEVEL_BASE)); // level zero
        send_word(KIND_CMD, 8'($urandom), CMD_SEND);
    endtask

    // Mostly well-formed press runs and level/send scripts, some noise.
    task automatic random_words(input int budget);
        int                 stop_at;
        int                 pick;
        int                 holds;
        logic [LINES_W-1:0] held;
        logic [LINES_W-1:0] lines;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                held = LINES_W'(1 << $urandom_range(LINES_W - 1));
                if ($urandom_range(2) == 0) held |= LINES_W'(1 << $urandom_range(LINES_W - 1));
                if ($urandom_range(7) == 0) held |= LINES_W'($urandom);
                holds = $urandom_range(5, 2);
                repeat (holds) begin
                    lines = ~held;
                    // bounce: one line glitches now and then
                    if ($urandom_range(5) == 0)
                        lines ^= LINES_W'(1 << $urandom_range(LINES_W - 1));
                    send_word(KIND_SAMPLE, lines, 8'($urandom));
                end
                send_word(KIND_SAMPLE, ALL_RELEASED, 8'($urandom));
            end else if (pick < 85) begin
                send_word(KIND_CMD, 8'($urandom), 8'($urandom_range(CMD_LEVEL_BASE - 1, 0)));
                send_word(KIND_CMD, 8'($urandom),
                          8'($urandom_range(CMD_LEVEL_END - 1, CMD_LEVEL_BASE)));
                if ($urandom_range(1) == 0) send_word(KIND_CMD, 8'($urandom), CMD_SEND);
            end else begin
                send_word(1'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        t_mask masks [NUM_MASKS];

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        in_bus.valid    <= 1'b0;
        in_bus.kind     <= KIND_SAMPLE;
        in_bus.buttons  <= ALL_RELEASED;
        in_bus.cmd_byte <= '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        words_sent      = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 0: reset masks, no idling on either side
        directed_words();
        directed_sent = words_sent;
        random_words(RANDOM_PER_PHASE);

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            settle();
            foreach (masks[i]) masks[i] = t_mask'($urandom);
            case (ph)
                1: begin
                    // every button toggles every channel
                    foreach (masks[i]) masks[i] = '1;
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    // empty mask, full mask, lowest and highest single channel
                    masks[0]       = '0;
                    masks[1]       = '1;
                    masks[2]       = 16'h0001;
                    masks[3]       = 16'h8000;
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            load_masks(masks);
            random_words(RANDOM_PER_PHASE);
        end

        settle();
        $display("Covered %0d input words (%0d directed) and %0d checked pair words,",
                 words_sent, directed_sent, pairs_checked);
        $display("across four mask settings with and without idling on each side.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
